// ===== rtl/mvsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared sizes, command and status codes, and the microcode store of the
// multi-voice sample mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

  // Sizes of the voice table and the sample store (store depth is a power of two).
  localparam int NUM_VOICES  = 8;
  localparam int STORE_DEPTH = 65536;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int VIDX_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  // Field widths.
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 17;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 3;

  // Address sum wide enough for start plus position at any store depth.
  localparam int ASUM_W = ((LEN_W + 1) > STORE_AW) ? (LEN_W + 1) : STORE_AW;

  // Mix accumulator: one sign bit and enough headroom for every voice.
  localparam int SUM_W = SAMPLE_W + VIDX_W + 1;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-(2 ** (SAMPLE_W - 1)));
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = SAMPLE_W'(2 ** (SAMPLE_W - 1));

  // Commands.
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MIX   = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Datapath micro-operations.
  localparam int UOP_W = 3;
  localparam logic [UOP_W-1:0] UOP_NOP   = 3'd0;
  localparam logic [UOP_W-1:0] UOP_WRITE = 3'd1;
  localparam logic [UOP_W-1:0] UOP_QUEUE = 3'd2;
  localparam logic [UOP_W-1:0] UOP_CLEAR = 3'd3;
  localparam logic [UOP_W-1:0] UOP_ISSUE = 3'd4;
  localparam logic [UOP_W-1:0] UOP_TAIL  = 3'd5;
  localparam logic [UOP_W-1:0] UOP_SAT   = 3'd6;

  // Sequencer jump conditions.
  localparam int JC_W = 3;
  localparam logic [JC_W-1:0] JC_NEXT     = 3'd0;
  localparam logic [JC_W-1:0] JC_JUMP     = 3'd1;
  localparam logic [JC_W-1:0] JC_DISPATCH = 3'd2;
  localparam logic [JC_W-1:0] JC_LOOP     = 3'd3;
  localparam logic [JC_W-1:0] JC_OUTPUT   = 3'd4;

  // Program steps.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_WRITE  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_QUEUE  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MIXCLR = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MIXRUN = 3'd4;
  localparam logic [STEP_W-1:0] STEP_MIXTL  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_MIXSAT = 3'd6;
  localparam logic [STEP_W-1:0] STEP_FINISH = 3'd7;

  typedef struct packed {
    logic [UOP_W-1:0]  uop;
    logic [JC_W-1:0]   jc;
    logic [STEP_W-1:0] target;
  } ucode_word_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic             start;
    logic [UOP_W-1:0] uop;
  } dp_ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic idx_last;
  } dp_stat_t;

  // One result beat.
  typedef struct packed {
    logic [SLOT_W-1:0]          slot_taken;
    logic [STATUS_W-1:0]        status;
    logic                       clipped;
    logic signed [SAMPLE_W-1:0] mixed_sample;
  } result_t;

  // Microcode store.
  function automatic ucode_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_word_t w;
    unique case (step)
      STEP_IDLE:   w = '{uop: UOP_NOP,   jc: JC_DISPATCH, target: STEP_IDLE};
      STEP_WRITE:  w = '{uop: UOP_WRITE, jc: JC_JUMP,     target: STEP_FINISH};
      STEP_QUEUE:  w = '{uop: UOP_QUEUE, jc: JC_JUMP,     target: STEP_FINISH};
      STEP_MIXCLR: w = '{uop: UOP_CLEAR, jc: JC_NEXT,     target: STEP_IDLE};
      STEP_MIXRUN: w = '{uop: UOP_ISSUE, jc: JC_LOOP,     target: STEP_MIXRUN};
      STEP_MIXTL:  w = '{uop: UOP_TAIL,  jc: JC_NEXT,     target: STEP_IDLE};
      STEP_MIXSAT: w = '{uop: UOP_SAT,   jc: JC_NEXT,     target: STEP_IDLE};
      STEP_FINISH: w = '{uop: UOP_NOP,   jc: JC_OUTPUT,   target: STEP_IDLE};
      default:     w = '{uop: UOP_NOP,   jc: JC_JUMP,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // Entry step for each command; the unused command goes straight to the result.
  function automatic logic [STEP_W-1:0] dispatch(input logic [CMD_W-1:0] cmd);
    logic [STEP_W-1:0] s;
    unique case (cmd)
      CMD_WRITE: s = STEP_WRITE;
      CMD_QUEUE: s = STEP_QUEUE;
      CMD_MIX:   s = STEP_MIXCLR;
      default:   s = STEP_FINISH;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/mvsm_sample_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_sample_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mvsm_sample_ram #(
  parameter int AW = 16,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mvsm_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_sequencer
// Step counter over the microcode store, with command dispatch, the voice
// loop and the wait for a free output register as conditional jumps.
// ----------------------------------------------------------------------------
module mvsm_sequencer
  import mvsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  input  dp_stat_t         stat,
  input  logic             out_free,
  output logic             in_ready,
  output logic             out_load,
  output dp_ctrl_t         ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_word_t       cw;
  logic              in_fire;

  assign cw       = ucode_rom(step);
  assign in_ready = (cw.jc == JC_DISPATCH);
  assign in_fire  = in_ready && in_valid;
  assign out_load = (cw.jc == JC_OUTPUT) && out_free;

  assign ctrl.start = in_fire;
  assign ctrl.uop   = cw.uop;

  // Next step from the jump condition of the current control word.
  always_comb begin
    step_next = step;
    unique case (cw.jc)
      JC_NEXT:     step_next = step + 1'b1;
      JC_JUMP:     step_next = cw.target;
      JC_DISPATCH: begin
        if (in_fire) begin
          step_next = dispatch(in_cmd);
        end
      end
      JC_LOOP:     step_next = stat.idx_last ? (step + 1'b1) : cw.target;
      JC_OUTPUT: begin
        if (out_free) begin
          step_next = cw.target;
        end
      end
      default:     step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/mvsm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_datapath
// Voice table, sample store, mix accumulator and saturation, driven by one
// micro-operation per cycle.
// ----------------------------------------------------------------------------
module mvsm_datapath
  import mvsm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  dp_ctrl_t                   ctrl,
  input  logic [ADDR_W-1:0]          in_address,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [LEN_W-1:0]           in_length,
  output dp_stat_t                   stat,
  output result_t                    result
);

  // Latched item.
  logic [ADDR_W-1:0]          address;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [LEN_W-1:0]           sound_length;

  // Voice table.
  logic [NUM_VOICES-1:0] voice_active;
  logic [ADDR_W-1:0]     voice_start    [NUM_VOICES];
  logic [LEN_W-1:0]      voice_length   [NUM_VOICES];
  logic [LEN_W-1:0]      voice_position [NUM_VOICES];

  // Mix loop.
  logic [VIDX_W-1:0]       idx;
  logic                    acc_en;
  logic signed [SUM_W-1:0] acc;

  // Store ports.
  logic [STORE_AW-1:0]        raddr;
  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SUM_W-1:0]    rdata_ext;

  // Derived values.
  logic [VIDX_W-1:0] free_idx;
  logic              any_free;
  logic [LEN_W-1:0]  pos_inc;
  logic              voice_done;
  logic              idx_ok;

  mvsm_sample_ram #(
    .AW (STORE_AW),
    .DW (SAMPLE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.uop == UOP_WRITE),
    .waddr (STORE_AW'(address)),
    .wdata (sample_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Store address of the current voice wraps around the store.
  assign raddr     = STORE_AW'(ASUM_W'(voice_start[idx]) + ASUM_W'(voice_position[idx]));
  assign rdata_ext = SUM_W'($signed(rdata));

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int v = NUM_VOICES - 1; v >= 0; v--) begin
      if (!voice_active[v]) begin
        free_idx = VIDX_W'(v);
        any_free = 1'b1;
      end
    end
  end

  // Position advance of the current voice; it ends after its last sample.
  assign pos_inc       = voice_position[idx] + 1'b1;
  assign voice_done    = (pos_inc >= voice_length[idx]) || (pos_inc == '0);
  assign idx_ok        = (32'(idx) < NUM_VOICES);
  assign stat.idx_last = (idx == VIDX_W'(NUM_VOICES - 1));

  // Item latch.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      address      <= in_address;
      sample_value <= in_sample;
      sound_length <= in_length;
    end
  end

  // Voice table updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_active <= '0;
      for (int v = 0; v < NUM_VOICES; v++) begin
        voice_start[v]    <= '0;
        voice_length[v]   <= '0;
        voice_position[v] <= '0;
      end
    end else begin
      case (ctrl.uop)
        UOP_QUEUE: begin
          if (sound_length != '0 && any_free) begin
            voice_active[free_idx]   <= 1'b1;
            voice_start[free_idx]    <= address;
            voice_length[free_idx]   <= sound_length;
            voice_position[free_idx] <= '0;
          end
        end
        UOP_ISSUE: begin
          if (idx_ok && voice_active[idx]) begin
            if (voice_done) begin
              voice_active[idx]   <= 1'b0;
              voice_position[idx] <= '0;
            end else begin
              voice_position[idx] <= pos_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Mix loop: read one voice per cycle, add the previous one's sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      acc_en <= 1'b0;
    end else begin
      case (ctrl.uop)
        UOP_CLEAR: begin
          idx    <= '0;
          acc_en <= 1'b0;
        end
        UOP_ISSUE: begin
          idx    <= idx + 1'b1;
          acc_en <= idx_ok && voice_active[idx];
        end
        UOP_TAIL: begin
          acc_en <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.uop)
      UOP_CLEAR: begin
        acc <= '0;
      end
      UOP_ISSUE, UOP_TAIL: begin
        if (acc_en) begin
          acc <= acc + rdata_ext;
        end
      end
      default: begin
      end
    endcase
  end

  // Result fields: cleared when an item is taken, set by queue and saturation.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      result <= '0;
    end else begin
      case (ctrl.uop)
        UOP_QUEUE: begin
          if (sound_length == '0) begin
            result.status <= ST_EMPTY;
          end else if (!any_free) begin
            result.status <= ST_FULL;
          end else begin
            result.status     <= ST_OK;
            result.slot_taken <= SLOT_W'(free_idx);
          end
        end
        UOP_SAT: begin
          if (acc > SUM_MAX) begin
            result.mixed_sample <= SAMPLE_MAX;
            result.clipped      <= 1'b1;
          end else if (acc < SUM_MIN) begin
            result.mixed_sample <= SAMPLE_MIN;
            result.clipped      <= 1'b1;
          end else begin
            result.mixed_sample <= SAMPLE_W'(acc);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/multi_voice_sample_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// Multi-voice PCM mixer with a sample store and saturating sum.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_axis stream, one per beat, with the command code
//   in tuser. Write stores a sample, queue starts a sound in the lowest free
//   voice slot, mix returns one saturated output sample. Every command gives
//   exactly one result beat on m_axis.
//   Timing: a write or a queue runs its own step and then the finish step,
//   which loads the output register once it is free; the unused command goes
//   straight to the finish step; a mix runs a clear step, the voice loop that
//   reads one voice from the store per cycle, a tail step and a saturation
//   step. The next command is taken in the cycle after the result is loaded.
//   One command is worked on at a time; a new one may be taken while a
//   finished result waits in the output register.
//   Reset clears the voice table and the output register; the sample store
//   is not cleared and must be written before voices read it.
//   When the receiver stalls, the result holds in the output register and
//   the next finished command waits in its last step until it drains.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer
  import mvsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // address[15:0], sample_value[31:16], sound_length[48:32]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // mixed_sample[15:0], clipped[16], status[18:17],
                                     // slot_taken[21:19]
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;
  result_t  result;
  result_t  out_data;
  logic     out_load;
  logic     out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  mvsm_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .stat     (stat),
    .out_free (out_free),
    .in_ready (s_axis_tready),
    .out_load (out_load),
    .ctrl     (ctrl)
  );

  mvsm_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .in_address (s_axis_tdata[15:0]),
    .in_sample  (s_axis_tdata[31:16]),
    .in_length  (s_axis_tdata[48:32]),
    .stat       (stat),
    .result     (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end

  assign m_axis_tdata = {2'b00, out_data};

endmodule

// ===== rtl/mvsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_checker
// Port-level checks of the mixer, bound to the top level.
// ----------------------------------------------------------------------------
module mvsm_checker
  import mvsm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [55:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A result beat waiting on the receiver holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // The output register is empty after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat valid after reset");

  // Only one command is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command taken while another is in progress");

  // A failed queue assigns no slot and mixes nothing.
  a_failed_queue: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[18:17] != ST_OK) |->
      (m_axis_tdata[21:19] == 3'd0) && (m_axis_tdata[16:0] == 17'd0))
    else $error("rejected queue carries a slot or a sample");

  // A clipped sample sits at one of the range limits.
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[16] |->
      (m_axis_tdata[15:0] == SAMPLE_MAX) || (m_axis_tdata[15:0] == SAMPLE_MIN))
    else $error("clipped sample not at a limit");

endmodule

bind multi_voice_sample_mixer mvsm_checker u_mvsm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/mix_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mix_result_checker
// Watches both streams of the sample mixer. It predicts the result of every
// accepted command beat from its own copy of the sample store and voice
// table, and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module mix_result_checker
  import mvsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // address[15:0], sample_value[31:16], sound_length[48:32]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,  // mixed_sample[15:0], clipped[16], status[18:17],
                                     // slot_taken[21:19]
  output int          mismatches,
  output int          pending
);

  // Shadow copy of the sample store and the voice table.
  logic [SAMPLE_W-1:0] pcm_store  [STORE_DEPTH];
  logic                voice_on   [NUM_VOICES];
  logic [ADDR_W-1:0]   voice_base [NUM_VOICES];
  logic [LEN_W-1:0]    voice_len  [NUM_VOICES];
  logic [LEN_W-1:0]    voice_pos  [NUM_VOICES];

  // Results still owed by the block, oldest first.
  result_t awaited_results [$];

  // Applies one command to the shadow state and returns the result it gives.
  function automatic result_t next_mixer_result(input logic [CMD_W-1:0]    cmd,
                                                input logic [ADDR_W-1:0]   addr,
                                                input logic [SAMPLE_W-1:0] smp,
                                                input logic [LEN_W-1:0]    len);
    result_t             r;
    int                  acc;
    int                  slot;
    int                  v;
    logic [ASUM_W-1:0]   sum_addr;
    r    = '0;
    acc  = 0;
    slot = -1;
    case (cmd)
      CMD_WRITE: begin
        pcm_store[STORE_AW'(addr)] = smp;
      end
      CMD_QUEUE: begin
        // An empty sound is turned away before any slot is looked at.
        if (len == '0) begin
          r.status = ST_EMPTY;
        end else begin
          for (v = 0; v < NUM_VOICES; v++) begin
            if (!voice_on[v] && slot < 0) slot = v;
          end
          if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            voice_on[slot]   = 1'b1;
            voice_base[slot] = addr;
            voice_len[slot]  = len;
            voice_pos[slot]  = '0;
            r.status         = ST_OK;
            r.slot_taken     = SLOT_W'(slot);
          end
        end
      end
      CMD_MIX: begin
        // Sum every active voice and step it; a voice past its end is freed.
        for (v = 0; v < NUM_VOICES; v++) begin
          if (voice_on[v]) begin
            sum_addr = ASUM_W'(voice_base[v]) + ASUM_W'(voice_pos[v]);
            acc = acc + $signed(pcm_store[sum_addr[STORE_AW-1:0]]);
            voice_pos[v] = voice_pos[v] + 1'b1;
            if (voice_pos[v] >= voice_len[v] || voice_pos[v] == '0) begin
              voice_on[v]  = 1'b0;
              voice_pos[v] = '0;
            end
          end
        end
        // Saturate to the sample range and flag the clip.
        if (acc > int'(SAMPLE_MAX)) begin
          acc       = int'(SAMPLE_MAX);
          r.clipped = 1'b1;
        end else if (acc < int'(SAMPLE_MIN)) begin
          acc       = int'(SAMPLE_MIN);
          r.clipped = 1'b1;
        end
        r.mixed_sample = SAMPLE_W'(acc);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Predict on every command beat, compare on every result beat.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    int      v;
    if (rst) begin
      for (v = 0; v < NUM_VOICES; v++) begin
        voice_on[v]   = 1'b0;
        voice_base[v] = '0;
        voice_len[v]  = '0;
        voice_pos[v]  = '0;
      end
      awaited_results.delete();
      mismatches = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(next_mixer_result(s_axis_tuser, s_axis_tdata[15:0],
                                                    s_axis_tdata[31:16],
                                                    s_axis_tdata[48:32]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[21:0]);
        if (awaited_results.size() == 0) begin
          $error("result beat with no command waiting: tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("mixed_sample", int'(want.mixed_sample), int'(got.mixed_sample));
          check_field("clipped", int'(want.clipped), int'(got.clipped));
          check_field("status", int'(want.status), int'(got.status));
          check_field("slot_taken", int'(want.slot_taken), int'(got.slot_taken));
          check_field("tdata padding", 0, int'(m_axis_tdata[23:22]));
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ===== tb/sv/multi_voice_sample_mixer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_test
// Drives command beats into the sample mixer under random stalls on both
// streams: a directed opening, then sounds loaded, queued and mixed at
// random, then a closing run of very long sounds. The checker beside the
// block predicts and compares; this module only gives the verdict.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer_test;
  import mvsm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_TARGET = 1560;   // commands sent by the end of the random part
  localparam int SHORT_MAX     = 40;     // longest sound in the random part
  localparam int LONG_READS    = 20;     // mixes played over the long sounds
  localparam int SETTLE_CYCLES = 4 * (NUM_VOICES + 5);
  localparam int IDLE_PCT      = 26;

  typedef struct {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } sound_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  logic        calm = 1'b0;   // no idling on either side while set
  int          mismatches;
  int          pending;
  int          sent = 0;
  sound_t      sounds [$];

  always #5 clk = ~clk;

  multi_voice_sample_mixer u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mix_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  // The receiver stalls at random unless a calm stretch is on.
  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Samples lean toward full scale so that sums clip often.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_W'($urandom_range(0, 255)) - SAMPLE_W'(128);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Filler for fields that a command does not use.
  function automatic logic [LEN_W-1:0] any_len();
    return LEN_W'($urandom_range(0, 65536));
  endfunction

  // Sends one command beat after a random idle gap and waits for its handshake.
  task automatic send_beat(input logic [CMD_W-1:0]    cmd,
                           input logic [ADDR_W-1:0]   addr,
                           input logic [SAMPLE_W-1:0] smp,
                           input logic [LEN_W-1:0]    len);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, len, smp, addr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (cmd != CMD_UNUSED) sent++;
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Stimulus and verdict.
  initial begin
    sound_t            snd;
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  len;
    int                i;
    int                n;
    int                pick;
    bit                paused;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: store ends, unused command, empty mix, empty sound.
    send_beat(CMD_WRITE, 16'h0000, SAMPLE_MAX, '0);
    send_beat(CMD_WRITE, 16'hFFFF, SAMPLE_MAX, LEN_W'(65536));
    send_beat(CMD_WRITE, 16'h0001, SAMPLE_MIN, '0);
    send_beat(CMD_UNUSED, 16'hFFFF, 16'hFFFF, LEN_W'(65536));
    send_beat(CMD_MIX, '0, '0, '0);
    send_beat(CMD_QUEUE, 16'h1234, 16'hFFFF, '0);
    // Fill every slot with a sound that wraps the store, then one too many.
    for (i = 0; i < NUM_VOICES; i++) send_beat(CMD_QUEUE, 16'hFFFF, '0, LEN_W'(2));
    send_beat(CMD_QUEUE, 16'h0000, '0, LEN_W'(1));
    // Positive clip on both samples, after which the table is empty again.
    send_beat(CMD_MIX, '0, '0, '0);
    send_beat(CMD_MIX, '0, '0, '0);
    // Negative clip, then a sum of both limits that stays in range.
    send_beat(CMD_QUEUE, 16'h0001, '0, LEN_W'(1));
    send_beat(CMD_QUEUE, 16'h0001, '0, LEN_W'(1));
    send_beat(CMD_MIX, '0, '0, '0);
    send_beat(CMD_QUEUE, 16'h0000, '0, LEN_W'(1));
    send_beat(CMD_QUEUE, 16'h0001, '0, LEN_W'(1));
    send_beat(CMD_MIX, '0, '0, '0);
    wait_drained();

    // Random part: sounds are written in full before they are queued.
    while (sent < RANDOM_TARGET) begin
      calm <= (sent >= 700 && sent < 950);
      if (!paused && sent >= 400) begin
        paused = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        snd.len   = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(13, SHORT_MAX))
                                                : LEN_W'($urandom_range(1, 12));
        snd.start = ADDR_W'($urandom);
        for (i = 0; i < int'(snd.len); i++) begin
          send_beat(CMD_WRITE, snd.start + ADDR_W'(i), pick_sample(), any_len());
        end
        send_beat(CMD_QUEUE, snd.start, pick_sample(), snd.len);
        sounds.push_back(snd);
      end else if (pick < 55 && sounds.size() > 0) begin
        snd = sounds[$urandom_range(0, sounds.size() - 1)];
        send_beat(CMD_QUEUE, snd.start, pick_sample(), snd.len);
      end else if (pick < 85) begin
        n = $urandom_range(1, 12);
        repeat (n) send_beat(CMD_MIX, ADDR_W'($urandom), pick_sample(), any_len());
      end else begin
        case ($urandom_range(0, 2))
          0:       send_beat(CMD_WRITE, ADDR_W'($urandom), pick_sample(), any_len());
          1:       send_beat(CMD_UNUSED, ADDR_W'($urandom), pick_sample(), any_len());
          default: send_beat(CMD_QUEUE, ADDR_W'($urandom), pick_sample(), '0);
        endcase
      end
    end
    calm <= 1'b0;

    // Play out every short sound so that all slots are free.
    repeat (SHORT_MAX) send_beat(CMD_MIX, ADDR_W'($urandom), pick_sample(), any_len());
    wait_drained();

    // Closing part: a block across the top of the store holds very long sounds.
    base = 16'hFFF0 - ADDR_W'($urandom_range(0, 8));
    for (i = 0; i < LONG_READS + 4; i++) begin
      send_beat(CMD_WRITE, base + ADDR_W'(i), pick_sample(), any_len());
    end
    for (i = 0; i < NUM_VOICES; i++) begin
      case (i)
        0:       len = LEN_W'(65536);
        1:       len = LEN_W'(65535);
        2:       len = LEN_W'(LONG_READS + 1);
        default: len = LEN_W'($urandom_range(LONG_READS + 1, 65536));
      endcase
      send_beat(CMD_QUEUE, base + ADDR_W'(i % 4), pick_sample(), len);
    end
    send_beat(CMD_QUEUE, base, pick_sample(), LEN_W'(65536));
    repeat (LONG_READS) send_beat(CMD_MIX, ADDR_W'($urandom), pick_sample(), any_len());

    // Let the last results drain, then give the verdict.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Timeout far beyond the slowest correct run.
  initial begin
    #(64'd4_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
